// File: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix to postfix converter
// Token kind codes, precedence table, stack entry layout and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package itp_pkg;

  // field widths of one item
  localparam int KIND_W  = 5;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int ENTRY_W = KIND_W + INDEX_W;
  localparam int PREC_W  = 3;

  // parameter defaults
  localparam int STACK_DEPTH_DEF = 32;
  localparam int MAX_TOKENS_DEF  = 256;

  // largest count the emitted counter can show
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  // token kind codes
  localparam logic [KIND_W-1:0] KIND_BLANK   = 5'd0;
  localparam logic [KIND_W-1:0] KIND_OPERAND = 5'd1;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 5'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSE   = 5'd4;
  localparam logic [KIND_W-1:0] KIND_ADD     = 5'd5;
  localparam logic [KIND_W-1:0] KIND_SUB     = 5'd6;
  localparam logic [KIND_W-1:0] KIND_MUL     = 5'd7;
  localparam logic [KIND_W-1:0] KIND_DIV     = 5'd8;
  localparam logic [KIND_W-1:0] KIND_MAX     = 5'd9;
  localparam logic [KIND_W-1:0] KIND_MIN     = 5'd10;
  localparam logic [KIND_W-1:0] KIND_POW     = 5'd11;
  localparam logic [KIND_W-1:0] KIND_SIN     = 5'd12;
  localparam logic [KIND_W-1:0] KIND_COS     = 5'd13;
  localparam logic [KIND_W-1:0] KIND_SQR     = 5'd14;
  localparam logic [KIND_W-1:0] KIND_SQRT    = 5'd15;
  localparam logic [KIND_W-1:0] KIND_OR      = 5'd16;
  localparam logic [KIND_W-1:0] KIND_AND     = 5'd17;
  localparam logic [KIND_W-1:0] KIND_LT      = 5'd18;
  localparam logic [KIND_W-1:0] KIND_LE      = 5'd19;
  localparam logic [KIND_W-1:0] KIND_GT      = 5'd20;
  localparam logic [KIND_W-1:0] KIND_GE      = 5'd21;
  localparam logic [KIND_W-1:0] KIND_EQ      = 5'd22;
  localparam logic [KIND_W-1:0] KIND_NE      = 5'd23;

  // operator precedence, brackets and non-operators at zero
  function automatic logic [PREC_W-1:0] prec_of(input logic [KIND_W-1:0] kind);
    logic [PREC_W-1:0] p;
    unique case (kind)
      KIND_MAX, KIND_MIN, KIND_POW:           p = 3'd7;
      KIND_MUL, KIND_DIV:                     p = 3'd6;
      KIND_ADD, KIND_SUB:                     p = 3'd5;
      KIND_SIN, KIND_COS, KIND_SQR, KIND_SQRT: p = 3'd4;
      KIND_LT, KIND_LE, KIND_GT, KIND_GE,
      KIND_EQ, KIND_NE:                       p = 3'd3;
      KIND_AND:                               p = 3'd2;
      KIND_OR:                                p = 3'd1;
      default:                                p = 3'd0;
    endcase
    return p;
  endfunction

  // unary functions go onto the stack without popping
  function automatic logic is_unary(input logic [KIND_W-1:0] kind);
    return (kind >= KIND_SIN) && (kind <= KIND_SQRT);
  endfunction

  // everything but a blank and the comma, bracket and operator codes is emitted at once
  function automatic logic is_operand(input logic [KIND_W-1:0] kind);
    return (kind != KIND_BLANK) && !((kind >= KIND_COMMA) && (kind <= KIND_NE));
  endfunction

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted input item
    logic push;      // push the held item onto the stack
    logic pop;       // drop the top entry
    logic emit;      // load the output register
    logic emit_top;  // emitted token comes from the top entry, else the held item
    logic emit_has;  // emitted result carries a token
    logic emit_end;  // emitted result closes the expression
    logic clear;     // reset counter and overflow flag for the next expression
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_end;     // held item is an end command
    logic item_blank;
    logic item_operand;
    logic item_open;
    logic item_close;
    logic item_comma;
    logic item_unary;
    logic fill_zero;
    logic fill_one;
    logic top_open;
    logic top_unary;
    logic top_wins;     // top entry precedence at least that of the held item
    logic out_free;     // output register can take a result this cycle
  } ctrl_status_t;

endpackage

// File: rtl/itp_datapath.sv
// ----------------------------------------------------------------------------
// itp_datapath: operator stack, counters and output register
// Holds the current item, the operator stack memory with a registered top
// entry, the emitted counter, the overflow flag and the result register.
// ----------------------------------------------------------------------------
module itp_datapath #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_TOKENS  = itp_pkg::MAX_TOKENS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  itp_pkg::ctrl_cmd_t           cmd_i,
  output itp_pkg::ctrl_status_t        sts_o,
  input  logic                         item_end_i,
  input  logic [itp_pkg::KIND_W-1:0]   item_kind_i,
  input  logic [itp_pkg::INDEX_W-1:0]  item_index_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [itp_pkg::KIND_W-1:0]   out_kind_o,
  output logic [itp_pkg::INDEX_W-1:0]  out_pos_o,
  output logic                         out_has_o,
  output logic                         out_end_o,
  output logic                         out_ovf_o,
  output logic [itp_pkg::COUNT_W-1:0]  out_count_o
);

  localparam int FillW = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = $clog2(STACK_DEPTH);
  localparam int CntLimitInt = (MAX_TOKENS < itp_pkg::COUNT_MAX) ?
                               MAX_TOKENS : itp_pkg::COUNT_MAX;
  localparam logic [itp_pkg::COUNT_W-1:0] CntLimit = itp_pkg::COUNT_W'(CntLimitInt);

  // held item
  logic                        item_end_q;
  logic [itp_pkg::KIND_W-1:0]  item_kind_q;
  logic [itp_pkg::INDEX_W-1:0] item_index_q;

  // stack state
  logic [itp_pkg::ENTRY_W-1:0] stack_mem [STACK_DEPTH];
  logic [itp_pkg::ENTRY_W-1:0] top_q;
  logic [FillW-1:0]            fill_q, fill_d, fill_dm1;
  logic                        full;
  logic                        wr_en;
  logic [AddrW-1:0]            wr_addr, rd_addr;
  logic [itp_pkg::ENTRY_W-1:0] wr_data;
  logic [itp_pkg::KIND_W-1:0]  top_kind;

  // counters and output register
  logic [itp_pkg::COUNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q, out_valid_d;
  logic [itp_pkg::KIND_W-1:0]  out_kind_q;
  logic [itp_pkg::INDEX_W-1:0] out_pos_q;
  logic                        out_has_q, out_end_q, out_ovf_q;
  logic [itp_pkg::COUNT_W-1:0] out_count_q;

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_end_q   <= item_end_i;
      item_kind_q  <= item_kind_i;
      item_index_q <= item_index_i;
    end
  end

  // stack pointer arithmetic
  always_comb begin
    full    = (fill_q == FillW'(STACK_DEPTH));
    wr_en   = cmd_i.push && !full;
    wr_addr = fill_q[AddrW-1:0];
    wr_data = {item_kind_q, item_index_q};
    if (wr_en) begin
      fill_d = fill_q + FillW'(1);
    end else if (cmd_i.pop) begin
      fill_d = fill_q - FillW'(1);
    end else begin
      fill_d = fill_q;
    end
    fill_dm1 = fill_d - FillW'(1);
    rd_addr  = (fill_d == '0) ? '0 : fill_dm1[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // stack memory, top register follows the next fill with write bypass
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      top_q <= wr_data;
    end else begin
      top_q <= stack_mem[rd_addr];
    end
  end

  assign top_kind = top_q[itp_pkg::ENTRY_W-1:itp_pkg::INDEX_W];

  // emitted counter and overflow flag
  always_comb begin
    cnt_next = cnt_q;
    if (cmd_i.emit_has && (cnt_q < CntLimit)) begin
      cnt_next = cnt_q + itp_pkg::COUNT_W'(1);
    end
    if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.emit) begin
      cnt_d = cnt_next;
    end else begin
      cnt_d = cnt_q;
    end
    if (cmd_i.clear) begin
      ovf_d = 1'b0;
    end else if (cmd_i.push && full) begin
      ovf_d = 1'b1;
    end else begin
      ovf_d = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  // output register
  always_comb begin
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (!cmd_i.emit_has) begin
        out_kind_q <= '0;
        out_pos_q  <= '0;
      end else if (cmd_i.emit_top) begin
        out_kind_q <= top_kind;
        out_pos_q  <= top_q[itp_pkg::INDEX_W-1:0];
      end else begin
        out_kind_q <= item_kind_q;
        out_pos_q  <= item_index_q;
      end
      out_has_q   <= cmd_i.emit_has;
      out_end_q   <= cmd_i.emit_end;
      out_ovf_q   <= ovf_q;
      out_count_q <= cnt_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_pos_o   = out_pos_q;
  assign out_has_o   = out_has_q;
  assign out_end_o   = out_end_q;
  assign out_ovf_o   = out_ovf_q;
  assign out_count_o = out_count_q;

  // status toward the controller
  always_comb begin
    sts_o.item_end     = item_end_q;
    sts_o.item_blank   = (item_kind_q == itp_pkg::KIND_BLANK);
    sts_o.item_operand = itp_pkg::is_operand(item_kind_q);
    sts_o.item_open    = (item_kind_q == itp_pkg::KIND_OPEN);
    sts_o.item_close   = (item_kind_q == itp_pkg::KIND_CLOSE);
    sts_o.item_comma   = (item_kind_q == itp_pkg::KIND_COMMA);
    sts_o.item_unary   = itp_pkg::is_unary(item_kind_q);
    sts_o.fill_zero    = (fill_q == '0);
    sts_o.fill_one     = (fill_q == FillW'(1));
    sts_o.top_open     = (top_kind == itp_pkg::KIND_OPEN);
    sts_o.top_unary    = itp_pkg::is_unary(top_kind);
    sts_o.top_wins     = (itp_pkg::prec_of(item_kind_q) <= itp_pkg::prec_of(top_kind));
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  // stack never grows past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  // the end of an expression leaves counter and flag clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (cnt_q == '0) && !ovf_q)
    else $error("counter or overflow flag not cleared");

  // a loaded result is shown on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted result not valid");

endmodule

// File: rtl/itp_controller.sv
// ----------------------------------------------------------------------------
// itp_controller: sequencing state machine
// Decodes the held item and steps the stack one pop or push per cycle,
// waiting on the output register when it is still full.
// ----------------------------------------------------------------------------
module itp_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  itp_pkg::ctrl_status_t sts_i,
  output itp_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_CLOSE    = 3'd2;
  localparam logic [2:0] S_CLOSE_FN = 3'd3;
  localparam logic [2:0] S_COMMA    = 3'd4;
  localparam logic [2:0] S_BINOP    = 3'd5;
  localparam logic [2:0] S_FLUSH    = 3'd6;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.item_end) begin
          state_d = S_FLUSH;
        end else if (sts_i.item_blank) begin
          state_d = S_IDLE;
        end else if (sts_i.item_close) begin
          state_d = S_CLOSE;
        end else if (sts_i.item_comma) begin
          state_d = S_COMMA;
        end else if (sts_i.item_open || sts_i.item_unary) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end else if (sts_i.item_operand) begin
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_has = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          state_d = S_BINOP;
        end
      end
      S_CLOSE: begin
        priority if (sts_i.fill_zero) begin
          state_d = S_IDLE;
        end else if (sts_i.top_open) begin
          // remove the matching bracket without output
          cmd_o.pop = 1'b1;
          state_d   = S_CLOSE_FN;
        end else if (sts_i.out_free) begin
          cmd_o.pop      = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.emit_top = 1'b1;
          cmd_o.emit_has = 1'b1;
        end
      end
      S_CLOSE_FN: begin
        if (!sts_i.fill_zero && sts_i.top_unary) begin
          if (sts_i.out_free) begin
            cmd_o.pop      = 1'b1;
            cmd_o.emit     = 1'b1;
            cmd_o.emit_top = 1'b1;
            cmd_o.emit_has = 1'b1;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_COMMA: begin
        if (!sts_i.fill_zero && !sts_i.top_open) begin
          if (sts_i.out_free) begin
            cmd_o.pop      = 1'b1;
            cmd_o.emit     = 1'b1;
            cmd_o.emit_top = 1'b1;
            cmd_o.emit_has = 1'b1;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BINOP: begin
        if (!sts_i.fill_zero && sts_i.top_wins) begin
          if (sts_i.out_free) begin
            cmd_o.pop      = 1'b1;
            cmd_o.emit     = 1'b1;
            cmd_o.emit_top = 1'b1;
            cmd_o.emit_has = 1'b1;
          end
        end else begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_end = sts_i.fill_zero || sts_i.fill_one;
          if (sts_i.fill_zero) begin
            // bare end marker
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.pop      = 1'b1;
            cmd_o.emit_top = 1'b1;
            cmd_o.emit_has = 1'b1;
            if (sts_i.fill_one) begin
              cmd_o.clear = 1'b1;
              state_d     = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // never push and pop in one step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.push && cmd_o.pop))
    else $error("push and pop together");

  // a result is only loaded when the output register has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result loaded into a full output register");

  // no pop from an empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> !sts_i.fill_zero)
    else $error("pop from empty stack");

endmodule

// File: rtl/infix_to_postfix_converter_top.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top: shunting-yard infix to postfix converter
// Reorders a stream of infix tokens into postfix order with an operator stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis group: tdata carries the token kind and
//   its infix position, tuser is set for an end command that flushes the
//   stack and closes the expression. Result items leave on the m_axis group
//   in postfix order; tlast marks the last result of an expression and tuser
//   tells a token from a bare end marker.
//   Timing: an item is accepted in the idle state and decoded in the next
//   cycle. A blank, '(' or a unary function is done at decode, an operand
//   once the output register is free. A binary operator, a comma and ')'
//   go on to a loop that pops one entry per cycle from the registered top
//   while the output register is free; a ')' also removes its matching
//   bracket. An end command pops every stack entry the same way, or emits
//   a bare end marker on an empty stack. An operand or a pop shows its
//   result in the cycle after it is made.
//   Reset empties the stack and clears the counter and overflow flag; the
//   stack memory itself is not cleared. When the receiver stalls, the
//   result waits in the output register and every pop that emits stops
//   until it is taken; no input is accepted until the current item is finished.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_TOKENS  = itp_pkg::MAX_TOKENS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // token_kind[4:0], token_index[12:5], zero pad
  input  logic        s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_kind[4:0], out_pos[12:5], overflow_seen[13], emitted_count[22:14], zero pad
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // has_token
  output logic        m_axis_tlast_o    // end_of_expr
);

  itp_pkg::ctrl_cmd_t          cmd;
  itp_pkg::ctrl_status_t       sts;
  logic [itp_pkg::KIND_W-1:0]  out_kind;
  logic [itp_pkg::INDEX_W-1:0] out_pos;
  logic                        out_ovf;
  logic [itp_pkg::COUNT_W-1:0] out_count;

  // sequencing
  itp_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stack, counters and output register
  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_TOKENS  (MAX_TOKENS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .item_end_i   (s_axis_tuser_i),
    .item_kind_i  (s_axis_tdata_i[4:0]),
    .item_index_i (s_axis_tdata_i[12:5]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_kind_o   (out_kind),
    .out_pos_o    (out_pos),
    .out_has_o    (m_axis_tuser_o),
    .out_end_o    (m_axis_tlast_o),
    .out_ovf_o    (out_ovf),
    .out_count_o  (out_count)
  );

  // result packing
  assign m_axis_tdata_o = {1'b0, out_count, out_ovf, out_pos, out_kind};

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for infix_to_postfix_converter_top
// Drives infix token streams on the input side and predicts the postfix
// result stream with its own copy of the operator stack. Results are compared
// field by field, in order. Stimulus starts with a short directed part, then
// one long expression that drives the count to saturation, then random
// well-formed expressions, noise and deep nesting under varied idling.
// ----------------------------------------------------------------------------
module testbench;
  import itp_pkg::*;

  localparam int ITEM_TARGET    = 425;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 60;
  localparam int COUNT_SAT      = (MAX_TOKENS_DEF < COUNT_MAX) ? MAX_TOKENS_DEF : COUNT_MAX;

  // unused kind codes are passed through like operands
  localparam logic [KIND_W-1:0] KIND_UNUSED_LOW = 5'd24;
  localparam logic [KIND_W-1:0] KIND_UNUSED_TOP = 5'd31;

  // one postfix result as seen on the output side
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic               has_tok;
    logic               last;
    logic               ovf;
    logic [COUNT_W-1:0] count;
  } postfix_tok_t;

  // operator stack predictor and queue of expected postfix results
  class postfix_scoreboard;
    postfix_tok_t       expected_q[$];
    logic [ENTRY_W-1:0] op_stk [STACK_DEPTH_DEF];
    int unsigned        fill;
    int unsigned        tok_count;
    bit                 ovf;
    int                 errors;

    function new();
      fill      = 0;
      tok_count = 0;
      ovf       = 1'b0;
      errors    = 0;
    endfunction

    function int unsigned rank(logic [KIND_W-1:0] k);
      case (k)
        KIND_MAX, KIND_MIN, KIND_POW:            return 7;
        KIND_MUL, KIND_DIV:                      return 6;
        KIND_ADD, KIND_SUB:                      return 5;
        KIND_SIN, KIND_COS, KIND_SQR, KIND_SQRT: return 4;
        KIND_LT, KIND_LE, KIND_GT, KIND_GE,
        KIND_EQ, KIND_NE:                        return 3;
        KIND_AND:                                return 2;
        KIND_OR:                                 return 1;
        default:                                 return 0;
      endcase
    endfunction

    function bit is_func(logic [KIND_W-1:0] k);
      return (k >= KIND_SIN) && (k <= KIND_SQRT);
    endfunction

    function logic [KIND_W-1:0] top_kind();
      return op_stk[fill-1][ENTRY_W-1:INDEX_W];
    endfunction

    function void add_result(logic [ENTRY_W-1:0] entry, bit has, bit last);
      postfix_tok_t r;
      if (has && tok_count < COUNT_SAT) tok_count++;
      r.kind    = entry[ENTRY_W-1:INDEX_W];
      r.index   = entry[INDEX_W-1:0];
      r.has_tok = has;
      r.last    = last;
      r.ovf     = ovf;
      r.count   = tok_count[COUNT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void pop_out(bit last);
      fill--;
      add_result(op_stk[fill], 1'b1, last);
    endfunction

    // a push onto a full stack is lost and flagged
    function void push_op(logic [ENTRY_W-1:0] entry);
      if (fill >= STACK_DEPTH_DEF) begin
        ovf = 1'b1;
      end else begin
        op_stk[fill] = entry;
        fill++;
      end
    endfunction

    // note one accepted input item and queue the results it causes
    function void note_input(bit cmd, logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx);
      logic [ENTRY_W-1:0] entry;
      entry = {kind, idx};
      if (cmd) begin
        // flush, or a bare end marker on an empty stack
        if (fill == 0) add_result('0, 1'b0, 1'b1);
        else while (fill > 0) pop_out(fill == 1);
        fill      = 0;
        tok_count = 0;
        ovf       = 1'b0;
      end else if (kind != KIND_BLANK) begin
        if (kind == KIND_OPEN) begin
          push_op(entry);
        end else if (kind == KIND_CLOSE) begin
          while (fill > 0 && top_kind() != KIND_OPEN) pop_out(1'b0);
          if (fill > 0) fill--;
          while (fill > 0 && is_func(top_kind())) pop_out(1'b0);
        end else if (kind == KIND_COMMA) begin
          while (fill > 0 && top_kind() != KIND_OPEN) pop_out(1'b0);
        end else if (kind < KIND_COMMA || kind > KIND_NE) begin
          add_result(entry, 1'b1, 1'b0);
        end else begin
          if (!is_func(kind))
            while (fill > 0 && rank(kind) <= rank(top_kind())) pop_out(1'b0);
          push_op(entry);
        end
      end
    endfunction

    task flag_error(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // compare one accepted result with the oldest expectation
    task check_result(postfix_tok_t got);
      postfix_tok_t want;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d index %0d", got.kind, got.index));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
        flag_error($sformatf("out_kind got %0d want %0d", got.kind, want.kind));
      if (got.index !== want.index)
        flag_error($sformatf("out_pos got %0d want %0d", got.index, want.index));
      if (got.has_tok !== want.has_tok)
        flag_error($sformatf("has_token got %0b want %0b", got.has_tok, want.has_tok));
      if (got.last !== want.last)
        flag_error($sformatf("end_of_expr got %0b want %0b", got.last, want.last));
      if (got.ovf !== want.ovf)
        flag_error($sformatf("overflow_seen got %0b want %0b", got.ovf, want.ovf));
      if (got.count !== want.count)
        flag_error($sformatf("emitted_count got %0d want %0d", got.count, want.count));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  postfix_scoreboard  conv_sb = new();
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 n_items = 0;
  int                 quiet_cycles = 0;
  logic [INDEX_W-1:0] idx_pos = '0;
  bit                 hold_req = 1'b0;
  bit                 hold_rx = 1'b0;

  logic [KIND_W-1:0] bin_ops [15] = '{KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MAX,
                                      KIND_MIN, KIND_POW, KIND_OR, KIND_AND, KIND_LT,
                                      KIND_LE, KIND_GT, KIND_GE, KIND_EQ, KIND_NE};

  infix_to_postfix_converter_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // receiver ready, with random stalls and the long hold-off
  always @(negedge clk) begin
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted here while the sender keeps going
  initial begin
    wait (hold_req);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  // check every accepted result
  always @(posedge clk) begin
    postfix_tok_t got;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got.kind    = m_axis_tdata[4:0];
      got.index   = m_axis_tdata[12:5];
      got.ovf     = m_axis_tdata[13];
      got.count   = m_axis_tdata[22:14];
      got.has_tok = m_axis_tuser;
      got.last    = m_axis_tlast;
      conv_sb.check_result(got);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[infix_to_postfix_converter_top] ERROR");
        $finish;
      end
    end
  end

  // offer one item and wait for its handshake
  task automatic send_item(input bit cmd, input logic [KIND_W-1:0] kind,
                           input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {3'b000, idx, kind};
    do @(posedge clk); while (!s_axis_tready);
    conv_sb.note_input(cmd, kind, idx);
    n_items++;
    @(negedge clk);
  endtask

  // sender pauses until all expected results are in
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (conv_sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [INDEX_W-1:0] next_index();
    if ($urandom_range(9) == 0) return INDEX_W'($urandom_range(255));
    idx_pos++;
    return idx_pos;
  endfunction

  function automatic logic [KIND_W-1:0] pick_operand();
    if ($urandom_range(3) == 0) return KIND_UNUSED_LOW + KIND_W'($urandom_range(7));
    return KIND_OPERAND;
  endfunction

  task automatic send_token(input logic [KIND_W-1:0] kind);
    send_item(1'b0, kind, next_index());
  endtask

  // well-formed expression with random content, stray blanks, then end
  task automatic gen_expr(input int len, input int paren_pct);
    int depth;
    int n;
    int r;
    bit want_operand;
    depth = 0;
    n = 0;
    want_operand = 1'b1;
    while (n < len) begin
      if ($urandom_range(99) < 4) send_item(1'b0, KIND_BLANK, INDEX_W'($urandom));
      r = $urandom_range(99);
      if (want_operand) begin
        if (r < paren_pct && depth < 12) begin
          // open bracket, or a function call: unary function then its bracket
          if (r < paren_pct / 2) send_token(KIND_SIN + KIND_W'($urandom_range(3)));
          send_token(KIND_OPEN);
          depth++;
        end else begin
          send_token(pick_operand());
          want_operand = 1'b0;
        end
      end else if (depth > 0 && r < paren_pct) begin
        send_token(KIND_CLOSE);
        depth--;
      end else if (depth > 0 && r < paren_pct + 8) begin
        send_token(KIND_COMMA);
        want_operand = 1'b1;
      end else begin
        send_token(bin_ops[$urandom_range(14)]);
        want_operand = 1'b1;
      end
      n++;
    end
    if (want_operand) send_token(pick_operand());
    // sometimes leave brackets open for the flush
    while (depth > 0 && $urandom_range(9) != 0) begin
      send_token(KIND_CLOSE);
      depth--;
    end
    send_item(1'b1, KIND_W'($urandom), INDEX_W'($urandom));
  endtask

  // nesting deeper than the stack, then unwinding of some or all levels
  task automatic gen_deep();
    int n;
    int i;
    n = $urandom_range(STACK_DEPTH_DEF + 1, STACK_DEPTH_DEF + 4);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_token(KIND_SIN + KIND_W'($urandom_range(3)));
      else send_token(KIND_OPEN);
    end
    send_token(pick_operand());
    for (i = $urandom_range(n); i > 0; i--) begin
      if ($urandom_range(4) == 0) begin
        send_token(bin_ops[$urandom_range(14)]);
        send_token(pick_operand());
      end
      send_token(KIND_CLOSE);
    end
    send_item(1'b1, KIND_W'($urandom), INDEX_W'($urandom));
  endtask

  // arbitrary kinds, indexes and early ends
  task automatic gen_noise();
    int n;
    int i;
    n = $urandom_range(3, 12);
    for (i = 0; i < n; i++) begin
      send_item(($urandom_range(15) == 0), KIND_W'($urandom), INDEX_W'($urandom));
    end
    send_item(1'b1, KIND_W'($urandom), INDEX_W'($urandom));
  endtask

  initial begin
    int base;
    int phase_len;
    int phase;
    int want_phase;
    int r;
    bit deep_done;
    deep_done = 1'b0;
    phase = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty flush, stray close and comma, precedence, brackets
    send_item(1'b1, KIND_UNUSED_TOP, 8'hff);
    send_item(1'b0, KIND_CLOSE, 8'd0);
    send_item(1'b0, KIND_COMMA, 8'd1);
    send_item(1'b0, KIND_OPERAND, 8'd0);
    send_item(1'b0, KIND_ADD, 8'd1);
    send_item(1'b0, KIND_UNUSED_TOP, 8'd2);
    send_item(1'b0, KIND_MUL, 8'd3);
    send_item(1'b0, KIND_UNUSED_LOW, 8'd4);
    send_item(1'b0, KIND_GE, 8'd5);
    send_item(1'b0, KIND_OPERAND, 8'd6);
    send_item(1'b0, KIND_EQ, 8'd7);
    send_item(1'b0, KIND_OPERAND, 8'd8);
    send_item(1'b0, KIND_CLOSE, 8'd9);
    send_item(1'b0, KIND_AND, 8'd10);
    send_item(1'b0, KIND_SIN, 8'd11);
    send_item(1'b0, KIND_OPEN, 8'd12);
    send_item(1'b0, KIND_OPERAND, 8'd13);
    send_item(1'b0, KIND_COMMA, 8'd14);
    send_item(1'b0, KIND_OPERAND, 8'd15);
    send_item(1'b0, KIND_CLOSE, 8'd16);
    send_item(1'b0, KIND_BLANK, 8'hff);
    send_item(1'b0, KIND_POW, 8'd254);
    send_item(1'b0, KIND_OPERAND, 8'd255);
    send_item(1'b1, KIND_BLANK, 8'd0);
    wait_drained();

    // long expression saturates the count, receiver held off meanwhile
    hold_req = 1'b1;
    gen_expr(COUNT_SAT + 8, 0);
    wait_drained();

    // random phases: sender idle, receiver stall, both
    base = n_items;
    phase_len = (ITEM_TARGET - base) / 3;
    if (phase_len < 1) phase_len = 1;
    while (n_items < ITEM_TARGET) begin
      want_phase = (n_items - base) / phase_len + 1;
      if (want_phase > 3) want_phase = 3;
      if (want_phase != phase) begin
        phase = want_phase;
        wait_drained();
        case (phase)
          1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
          default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
      end
      r = $urandom_range(99);
      if (phase == 3 && !deep_done) begin
        gen_deep();
        deep_done = 1'b1;
      end else if (r < 4) begin
        gen_deep();
      end else if (r < 20) begin
        gen_noise();
      end else begin
        gen_expr($urandom_range(1, 12), 30);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (conv_sb.errors == 0 && conv_sb.expected_q.size() == 0) begin
      $display("[infix_to_postfix_converter_top] OK");
    end else begin
      $display("[infix_to_postfix_converter_top] ERROR");
    end
    $finish;
  end

endmodule
